// ----- rtl/bpc_pkg.sv -----
// shared types and constants for the barometric pressure compensation block
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

  // divider chain geometry
  localparam int DVD_W     = 32;
  localparam int DVS_W     = 18;
  localparam int DIV_CELLS = DVD_W;

  // calibration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_AC1_AC2 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AC3_AC4 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AC5_AC6 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B1_B2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MC_MD   = 3'd4;

  // formula constants
  localparam logic [31:0] B6_OFFSET   = 32'd4000;
  localparam logic [31:0] OSS_SCALE   = 32'd50000;
  localparam logic [31:0] B4_BIAS     = 32'd32768;
  localparam logic [31:0] P_C3038     = 32'd3038;
  localparam logic [31:0] P_CM7357    = 32'hFFFF_E343;
  localparam logic [31:0] P_C3791     = 32'd3791;

  // side data riding along the temperature divider
  typedef struct packed {
    logic        fault;
    logic        neg;
    logic [17:0] x1t;
    logic [23:0] up_raw;
    logic [1:0]  oss;
  } ttag_t;

  // side data riding along the pressure divider
  typedef struct packed {
    logic        fault;
    logic        hi;
    logic [15:0] t;
  } ptag_t;

  localparam int TAG_W = $bits(ttag_t);

  // one link of the divider chain
  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [DVS_W-1:0] rem;
    logic [DVD_W-1:0] dq;
    logic [DVS_W-1:0] dvs;
  } div_t;

endpackage

`default_nettype wire

// ----- rtl/bpc_sample_if.sv -----
// input channel carrying raw sensor readings
`timescale 1ns / 1ps
`default_nettype none

interface bpc_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_temp;
  logic [23:0] raw_press_bytes;
  logic [1:0]  oversampling;

  modport source (output valid, raw_temp, raw_press_bytes, oversampling, input ready);
  modport sink (input valid, raw_temp, raw_press_bytes, oversampling, output ready);
endinterface

`default_nettype wire

// ----- rtl/bpc_result_if.sv -----
// output channel carrying compensated results
`timescale 1ns / 1ps
`default_nettype none

interface bpc_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temp_tenths;
  logic signed [31:0] press_pascal;
  logic               divide_fault;

  modport source (output valid, temp_tenths, press_pascal, divide_fault, input ready);
  modport sink (input valid, temp_tenths, press_pascal, divide_fault, output ready);
endinterface

`default_nettype wire

// ----- rtl/bpc_cfg_if.sv -----
// calibration register write channel
`timescale 1ns / 1ps
`default_nettype none

interface bpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/bpc_div_cell.sv -----
// one restoring division step: one quotient bit per cell
`timescale 1ns / 1ps
`default_nettype none

module bpc_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  bpc_pkg::div_t d,
  output bpc_pkg::div_t q
);
  import bpc_pkg::*;

  logic [DVS_W:0]   trial;
  logic             ge;
  logic             vld;
  logic [TAG_W-1:0] tag;
  logic [DVS_W-1:0] rem;
  logic [DVD_W-1:0] dq;
  logic [DVS_W-1:0] dvs;

  // shift in the next dividend bit and try the subtract
  assign trial = {d.rem, d.dq[DVD_W-1]};
  assign ge    = trial >= {1'b0, d.dvs};

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= d.valid;
    end
  end

  // partial remainder, dividend/quotient shift word, divisor and side data
  always_ff @(posedge clk) begin
    if (en) begin
      tag <= d.tag;
      dvs <= d.dvs;
      dq  <= {d.dq[DVD_W-2:0], ge};
      rem <= ge ? DVS_W'(trial - {1'b0, d.dvs}) : trial[DVS_W-1:0];
    end
  end

  assign q = '{valid: vld, tag: tag, rem: rem, dq: dq, dvs: dvs};

endmodule

`default_nettype wire

// ----- rtl/bpc_div_chain.sv -----
// row of division cells, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none

module bpc_div_chain (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  bpc_pkg::div_t d,
  output bpc_pkg::div_t q
);
  import bpc_pkg::*;

  div_t link [DIV_CELLS+1];

  assign link[0] = d;

  // cells hand their word to the neighbor every enabled cycle
  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
    bpc_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (link[i]),
      .q   (link[i+1])
    );
  end

  assign q = link[DIV_CELLS];

endmodule

`default_nettype wire

// ----- rtl/barometric_pressure_compensation.sv -----
// Pressure/temperature compensation pipeline; the calibration port is always ready.
// Throughput: one request per cycle; the two 32-cell divider chains set the depth.
// The whole pipeline holds while a finished result is not taken.
// Reset clears the stage valid bits and the five calibration registers to zero.
// Calibration must be written only while the pipeline is empty; no check enforces it.
`timescale 1ns / 1ps
`default_nettype none

module barometric_pressure_compensation (
  input  logic            clk,
  input  logic            rst,
  bpc_sample_if.sink      sample,
  bpc_result_if.source    result,
  bpc_cfg_if.sink         cfg
);
  import bpc_pkg::*;

  // calibration registers
  logic [31:0] cal_ac1_ac2, cal_ac3_ac4, cal_ac5_ac6, cal_b1_b2, cal_mc_md;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_ac1_ac2 <= '0;
      cal_ac3_ac4 <= '0;
      cal_ac5_ac6 <= '0;
      cal_b1_b2   <= '0;
      cal_mc_md   <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_AC1_AC2: cal_ac1_ac2 <= cfg.data;
        REG_AC3_AC4: cal_ac3_ac4 <= cfg.data;
        REG_AC5_AC6: cal_ac5_ac6 <= cfg.data;
        REG_B1_B2:   cal_b1_b2   <= cfg.data;
        REG_MC_MD:   cal_mc_md   <= cfg.data;
        default: ;
      endcase
    end
  end

  // calibration fields
  logic [15:0] ac4, ac5, ac6;
  logic signed [15:0] mc, md;
  logic [31:0] ac1_32, ac2_32, ac3_32, b1_32, b2_32;

  assign ac4    = cal_ac3_ac4[15:0];
  assign ac5    = cal_ac5_ac6[31:16];
  assign ac6    = cal_ac5_ac6[15:0];
  assign mc     = cal_mc_md[31:16];
  assign md     = cal_mc_md[15:0];
  assign ac1_32 = {{16{cal_ac1_ac2[31]}}, cal_ac1_ac2[31:16]};
  assign ac2_32 = {{16{cal_ac1_ac2[15]}}, cal_ac1_ac2[15:0]};
  assign ac3_32 = {{16{cal_ac3_ac4[31]}}, cal_ac3_ac4[31:16]};
  assign b1_32  = {{16{cal_b1_b2[31]}}, cal_b1_b2[31:16]};
  assign b2_32  = {{16{cal_b1_b2[15]}}, cal_b1_b2[15:0]};

  // pipeline enable and stage valid bits
  logic        en;
  logic [13:0] vld;
  div_t        tin, tout, pin, pout;

  assign en           = !result.valid || result.ready;
  assign sample.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[12:10], pout.valid, vld[8:3], tout.valid, vld[1:0], sample.valid};
    end
  end

  // stage 0: capture request
  logic [15:0] ut0;
  logic [23:0] upr0;
  logic [1:0]  oss0;

  always_ff @(posedge clk) begin
    if (en) begin
      ut0  <= sample.raw_temp;
      upr0 <= sample.raw_press_bytes;
      oss0 <= sample.oversampling;
    end
  end

  // stage 1: (ut - ac6) * ac5
  logic signed [16:0] d17;
  logic signed [33:0] prod_next, prod1;
  logic [23:0] upr1;
  logic [1:0]  oss1;

  assign d17       = $signed({1'b0, ut0}) - $signed({1'b0, ac6});
  assign prod_next = d17 * $signed({1'b0, ac5});

  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= prod_next;
      upr1  <= upr0;
      oss1  <= oss0;
    end
  end

  // stage 2: x1t, divisor magnitude and dividend magnitude
  logic signed [33:0] adj;
  logic signed [17:0] x1t_c;
  logic signed [18:0] den_c;
  logic [DVS_W-1:0]   dvs_c;
  logic [16:0]        mc_mag;
  ttag_t              ttag_c;
  logic [TAG_W-1:0]   tin_tag;
  logic [DVD_W-1:0]   tin_dq;
  logic [DVS_W-1:0]   tin_dvs;

  assign adj    = prod1[33] ? prod1 + 34'sd32767 : prod1;
  assign x1t_c  = adj[32:15];
  assign den_c  = $signed({x1t_c[17], x1t_c}) + $signed({{3{md[15]}}, md});
  assign dvs_c  = den_c[18] ? DVS_W'(-den_c) : den_c[DVS_W-1:0];
  assign mc_mag = mc[15] ? 17'(-$signed({mc[15], mc})) : {1'b0, mc};
  assign ttag_c = '{fault: den_c == 19'sd0, neg: mc[15] ^ den_c[18], x1t: x1t_c,
                    up_raw: upr1, oss: oss1};

  always_ff @(posedge clk) begin
    if (en) begin
      tin_tag <= ttag_c;
      tin_dq  <= DVD_W'({mc_mag, 11'b0});
      tin_dvs <= dvs_c;
    end
  end

  assign tin = '{valid: vld[2], tag: tin_tag, rem: '0, dq: tin_dq, dvs: tin_dvs};

  // temperature divider: mc * 2048 / (x1t + md)
  bpc_div_chain u_tdiv (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .d   (tin),
    .q   (tout)
  );

  // stage 3: signed quotient and b5
  ttag_t              ttag;
  logic signed [27:0] qs, x2t;
  logic signed [28:0] b5_next, b5;
  logic [23:0] upr3;
  logic [1:0]  oss3;
  logic        fault3;

  assign ttag    = ttag_t'(tout.tag);
  assign qs      = $signed({1'b0, tout.dq[26:0]});
  assign x2t     = ttag.neg ? -qs : qs;
  assign b5_next = $signed({{11{ttag.x1t[17]}}, ttag.x1t}) + $signed({x2t[27], x2t});

  always_ff @(posedge clk) begin
    if (en) begin
      b5     <= b5_next;
      upr3   <= ttag.up_raw;
      oss3   <= ttag.oss;
      fault3 <= ttag.fault;
    end
  end

  // stage 4: rounded temperature, b6 and aligned pressure
  logic signed [28:0] ts, tf;
  logic [15:0] t_next, t4;
  logic [31:0] b6;
  logic [18:0] up4;
  logic [1:0]  oss4;
  logic        fault4;

  assign ts = b5 + 29'sd8;
  assign tf = ts[28] ? (ts + 29'sd15) >>> 4 : ts >>> 4;

  always_comb begin
    if (tf > 29'sd32767) begin
      t_next = 16'h7FFF;
    end else if (tf < -29'sd32768) begin
      t_next = 16'h8000;
    end else begin
      t_next = tf[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t4     <= t_next;
      b6     <= {{3{b5[28]}}, b5} - B6_OFFSET;
      up4    <= 19'(upr3 >> (4'd8 - {2'b0, oss3}));
      oss4   <= oss3;
      fault4 <= fault3;
    end
  end

  // stage 5: products of b6
  logic [31:0] b6sq, mac2, mac3;
  logic [15:0] t5;
  logic [18:0] up5;
  logic [1:0]  oss5;
  logic        fault5;

  always_ff @(posedge clk) begin
    if (en) begin
      b6sq   <= 32'(b6 * b6);
      mac2   <= 32'(ac2_32 * b6);
      mac3   <= 32'(ac3_32 * b6);
      t5     <= t4;
      up5    <= up4;
      oss5   <= oss4;
      fault5 <= fault4;
    end
  end

  // stage 6: products of the scaled square
  logic [31:0] sq, x2a_c, x1c_c, mb2, mb1, x2a, x1c;
  logic [15:0] t6;
  logic [18:0] up6;
  logic [1:0]  oss6;
  logic        fault6;

  assign sq    = $signed(b6sq) >>> 12;
  assign x2a_c = $signed(mac2) >>> 11;
  assign x1c_c = $signed(mac3) >>> 13;

  always_ff @(posedge clk) begin
    if (en) begin
      mb2    <= 32'(b2_32 * sq);
      mb1    <= 32'(b1_32 * sq);
      x2a    <= x2a_c;
      x1c    <= x1c_c;
      t6     <= t5;
      up6    <= up5;
      oss6   <= oss5;
      fault6 <= fault5;
    end
  end

  // stage 7: b3 and the b4 term
  logic [31:0] mb2_s, mb1_s, x3a, b3_pre, b3_c, x3b_pre, x3b_c, b3, x3b;
  logic [15:0] t7;
  logic [18:0] up7;
  logic [1:0]  oss7;
  logic        fault7;

  assign mb2_s   = $signed(mb2) >>> 11;
  assign mb1_s   = $signed(mb1) >>> 16;
  assign x3a     = mb2_s + x2a;
  assign b3_pre  = (((ac1_32 << 2) + x3a) << oss6) + 32'd2;
  assign b3_c    = $signed(b3_pre) >>> 2;
  assign x3b_pre = x1c + mb1_s + 32'd2;
  assign x3b_c   = $signed(x3b_pre) >>> 2;

  always_ff @(posedge clk) begin
    if (en) begin
      b3     <= b3_c;
      x3b    <= x3b_c;
      t7     <= t6;
      up7    <= up6;
      oss7   <= oss6;
      fault7 <= fault6;
    end
  end

  // stage 8: b4 product and up - b3
  logic [31:0] mb4, diff;
  logic [15:0] t8;
  logic [1:0]  oss8;
  logic        fault8;

  always_ff @(posedge clk) begin
    if (en) begin
      mb4    <= 32'({16'b0, ac4} * (x3b + B4_BIAS));
      diff   <= {13'b0, up7} - b3;
      t8     <= t7;
      oss8   <= oss7;
      fault8 <= fault7;
    end
  end

  // stage 9: b4 and b7
  logic [16:0] b4;
  logic [31:0] b7;
  logic [15:0] t9;
  logic        fault9;

  always_ff @(posedge clk) begin
    if (en) begin
      b4     <= mb4[31:15];
      b7     <= 32'(diff * (OSS_SCALE >> oss8));
      t9     <= t8;
      fault9 <= fault8;
    end
  end

  // pressure divider input: b7 doubled unless its top bit is set
  ptag_t ptag_c;

  assign ptag_c = '{fault: fault9 | (b4 == 17'd0), hi: b7[31], t: t9};
  assign pin    = '{valid: vld[9], tag: TAG_W'(ptag_c), rem: '0,
                    dq: b7[31] ? b7 : {b7[30:0], 1'b0}, dvs: {1'b0, b4}};

  bpc_div_chain u_pdiv (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .d   (pin),
    .q   (pout)
  );

  // stage 10: raw pressure
  ptag_t       ptag;
  logic [31:0] p10;
  logic [15:0] t10;
  logic        fault10;

  assign ptag = ptag_t'(pout.tag[$bits(ptag_t)-1:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      p10     <= ptag.hi ? {pout.dq[30:0], 1'b0} : pout.dq;
      t10     <= ptag.t;
      fault10 <= ptag.fault;
    end
  end

  // stage 11: correction products
  logic [31:0] xs, sqp, m7357, p11;
  logic [15:0] t11;
  logic        fault11;

  assign xs = $signed(p10) >>> 8;

  always_ff @(posedge clk) begin
    if (en) begin
      sqp     <= 32'(xs * xs);
      m7357   <= 32'(p10 * P_CM7357);
      p11     <= p10;
      t11     <= t10;
      fault11 <= fault10;
    end
  end

  // stage 12: scaled square term
  logic [31:0] m3038, x2p_c, x2p, p12;
  logic [15:0] t12;
  logic        fault12;

  assign x2p_c = $signed(m7357) >>> 16;

  always_ff @(posedge clk) begin
    if (en) begin
      m3038   <= 32'(sqp * P_C3038);
      x2p     <= x2p_c;
      p12     <= p11;
      t12     <= t11;
      fault12 <= fault11;
    end
  end

  // stage 13: final pressure and output register
  logic [31:0] x1p, corr_pre, corr, p_final;
  logic signed [15:0] temp_q;
  logic signed [31:0] press_q;
  logic               fault_q;

  assign x1p      = $signed(m3038) >>> 16;
  assign corr_pre = x1p + x2p + P_C3791;
  assign corr     = $signed(corr_pre) >>> 4;
  assign p_final  = p12 + corr;

  always_ff @(posedge clk) begin
    if (en) begin
      temp_q  <= fault12 ? 16'sd0 : $signed(t12);
      press_q <= fault12 ? 32'sd0 : $signed(p_final);
      fault_q <= fault12;
    end
  end

  assign result.valid        = vld[13];
  assign result.temp_tenths  = temp_q;
  assign result.press_pascal = press_q;
  assign result.divide_fault = fault_q;

  // a faulted result carries zero fields
  a_fault_zero : assert property (@(posedge clk) disable iff (rst)
    result.valid && result.divide_fault |-> result.temp_tenths == 16'sd0 &&
    result.press_pascal == 32'sd0)
    else $error("faulted result with nonzero fields");

  // a held pipeline keeps the occupancy of every stage outside the divider chains
  a_hold : assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("stage valid bits moved during a hold");

  // an accepted request occupies the first stage
  a_enter : assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> vld[0])
    else $error("accepted request lost at entry");

endmodule

`default_nettype wire

// ----- tb/barometric_pressure_compensation_tb.sv -----
// testbench for the barometric pressure compensation pipeline
`timescale 1ns / 1ps

module barometric_pressure_compensation_tb;
  import bpc_pkg::*;

  localparam int PIPE_LAT = 77;

  typedef struct {
    logic signed [15:0] temp_tenths;
    logic signed [31:0] press_pascal;
    logic               divide_fault;
  } comp_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bpc_sample_if sample ();
  bpc_result_if result ();
  bpc_cfg_if    cfg ();

  barometric_pressure_compensation DUT (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .result (result),
    .cfg    (cfg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the calibration words
  logic [31:0] cal_words [0:4];
  comp_result_t expected_q [$];
  int mismatches = 0;
  bit stall_enable = 1'b1;

  // arithmetic right shift of a 32-bit word
  function automatic logic [31:0] sra32(logic [31:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic longint sext16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  // compensated temperature and pressure for one request
  function automatic comp_result_t compensate(logic [15:0] ut_in, logic [23:0] up_raw,
                                              logic [1:0] oss);
    comp_result_t r;
    longint ut, ac5, ac6, mc, md, x1t, den, x2t, b5, t;
    logic [31:0] ac1, ac2, ac3, ac4, b1, b2;
    logic [31:0] up, b6, sq, x1, x2, x3, b3, b4, b7, p;
    ut  = longint'(ut_in);
    ac1 = 32'(sext16(cal_words[0][31:16]));
    ac2 = 32'(sext16(cal_words[0][15:0]));
    ac3 = 32'(sext16(cal_words[1][31:16]));
    ac4 = {16'd0, cal_words[1][15:0]};
    ac5 = longint'(cal_words[2][31:16]);
    ac6 = longint'(cal_words[2][15:0]);
    b1  = 32'(sext16(cal_words[3][31:16]));
    b2  = 32'(sext16(cal_words[3][15:0]));
    mc  = sext16(cal_words[4][31:16]);
    md  = sext16(cal_words[4][15:0]);
    r.temp_tenths  = '0;
    r.press_pascal = '0;
    r.divide_fault = 1'b1;
    // temperature, exact with truncating divides
    x1t = ((ut - ac6) * ac5) / 32768;
    den = x1t + md;
    if (den == 0) return r;
    x2t = (mc * 2048) / den;
    b5 = x1t + x2t;
    t = (b5 + 8) / 16;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    // pressure, wrapping 32-bit
    up = 32'(up_raw) >> (8 - oss);
    b6 = 32'(b5) - B6_OFFSET;
    sq = sra32(b6 * b6, 12);
    x1 = sra32(b2 * sq, 11);
    x2 = sra32(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = sra32(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
    x1 = sra32(ac3 * b6, 13);
    x2 = sra32(b1 * sq, 16);
    x3 = sra32(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + B4_BIAS)) >> 15;
    if (b4 == 0) return r;
    b7 = (up - b3) * (OSS_SCALE >> oss);
    if (b7 < 32'h8000_0000) p = (b7 << 1) / b4;
    else p = (b7 / b4) << 1;
    x1 = sra32(p, 8);
    x1 = x1 * x1;
    x1 = sra32(x1 * P_C3038, 16);
    x2 = sra32(p * P_CM7357, 16);
    p = p + sra32(x1 + x2 + P_C3791, 4);
    r.temp_tenths  = t[15:0];
    r.press_pascal = p;
    r.divide_fault = 1'b0;
    return r;
  endfunction

  function automatic int gap_len();
    if (!stall_enable) return 0;
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // send one sample request; valid stays high into a back-to-back request
  task automatic send_sample(logic [15:0] ut, logic [23:0] up, logic [1:0] oss);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      sample.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    expected_q.push_back(compensate(ut, up, oss));
    sample.valid           <= 1'b1;
    sample.raw_temp        <= ut;
    sample.raw_press_bytes <= up;
    sample.oversampling    <= oss;
    do @(posedge clk); while (!sample.ready);
  endtask

  task automatic write_cal(logic [2:0] idx, logic [31:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    if (idx <= REG_MC_MD) cal_words[idx] = val;
  endtask

  // wait for the pipeline to empty before touching calibration
  task automatic drain();
    int guard;
    guard = 0;
    sample.valid <= 1'b0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (PIPE_LAT + 5) @(posedge clk);
  endtask

  task automatic load_cal(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
                          logic [31:0] w3, logic [31:0] w4);
    drain();
    write_cal(REG_AC1_AC2, w0);
    write_cal(REG_AC3_AC4, w1);
    write_cal(REG_AC5_AC6, w2);
    write_cal(REG_B1_B2, w3);
    write_cal(REG_MC_MD, w4);
    cfg.valid <= 1'b0;
  endtask

  // datasheet-like calibration
  task automatic load_typical();
    load_cal({16'd408, -16'sd72}, {-16'sd14383, 16'd32741}, {16'd32757, 16'd23153},
             {16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
  endtask

  // reset calibration gives a zero divisor on every request
  task automatic test_zero_cal();
    send_sample(16'd0, 24'd0, 2'd0);
    send_sample(16'hFFFF, 24'hFFFFFF, 2'd3);
  endtask

  task automatic test_directed();
    int i;
    load_typical();
    send_sample(16'd27898, 24'h5D23 << 8, 2'd0);
    for (i = 0; i < 4; i++) begin
      send_sample(16'd0, 24'd0, 2'(i));
      send_sample(16'hFFFF, 24'hFFFFFF, 2'(i));
      send_sample(16'h5555, 24'hAAAAAA, 2'(i));
      send_sample(16'hAAAA, 24'h555555, 2'(i));
    end
    // temperature divisor zero: ac5 = 0, md = 0
    load_cal(32'h0198_FFB8, 32'hC7D1_7FE5, 32'h0000_5A71, 32'h182E_0004, 32'hDDF9_0000);
    send_sample(16'd27898, 24'h123456, 2'd1);
    // pressure divisor zero: ac4 = 0
    load_cal(32'h0198_FFB8, 32'hC7D1_0000, 32'h7FF5_5A71, 32'h182E_0004, 32'hDDF9_0B34);
    send_sample(16'd27898, 24'h123456, 2'd2);
    // extreme calibration, saturating temperature and wrapping pressure
    load_cal(32'h7FFF_8000, 32'h8000_FFFF, 32'hFFFF_0000, 32'h7FFF_8000, 32'h8000_0001);
    send_sample(16'hFFFF, 24'hFFFFFF, 2'd3);
    send_sample(16'd0, 24'd0, 2'd0);
    load_cal(32'h8000_7FFF, 32'h7FFF_0001, 32'h0001_FFFF, 32'h8000_7FFF, 32'h7FFF_FFFF);
    send_sample(16'hFFFF, 24'hFFFFFF, 2'd0);
    send_sample(16'd0, 24'h800000, 2'd3);
  endtask

  task automatic test_random();
    int i, j;
    for (j = 0; j < 5; j++) begin
      if (j == 0) load_typical();
      else load_cal($urandom, $urandom, $urandom, $urandom, $urandom);
      stall_enable = (j != 2);
      for (i = 0; i < 200; i++) begin
        if (j < 2 || $urandom_range(0, 3) != 0)
          send_sample(16'($urandom_range(20000, 40000)), 24'($urandom), 2'($urandom));
        else
          send_sample(16'($urandom), 24'($urandom), 2'($urandom));
      end
    end
    stall_enable = 1'b1;
  endtask

  // result ready, with random stalls while stall_enable is set
  always @(posedge clk) begin
    if (rst) result.ready <= 1'b0;
    else if (!stall_enable) result.ready <= 1'b1;
    else result.ready <= ($urandom_range(0, 9) < 7) ||
                         ($urandom_range(0, 99) < 2 ? 1'b0 : result.ready);
  end

  // result checker
  always @(posedge clk) begin
    comp_result_t exp_r;
    if (!rst && result.valid && result.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d %0d %0b",
                                       result.temp_tenths, result.press_pascal,
                                       result.divide_fault);
      end else begin
        exp_r = expected_q.pop_front();
        if (result.temp_tenths !== exp_r.temp_tenths ||
            result.press_pascal !== exp_r.press_pascal ||
            result.divide_fault !== exp_r.divide_fault) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp t=%0d p=%0d f=%0b got t=%0d p=%0d f=%0b",
                     exp_r.temp_tenths, exp_r.press_pascal, exp_r.divide_fault,
                     result.temp_tenths, result.press_pascal, result.divide_fault);
        end
      end
    end
  end

  initial begin
    sample.valid           = 1'b0;
    sample.raw_temp        = '0;
    sample.raw_press_bytes = '0;
    sample.oversampling    = '0;
    cfg.valid              = 1'b0;
    cfg.index              = '0;
    cfg.data               = '0;
    for (int k = 0; k < 5; k++) cal_words[k] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_zero_cal();
    test_directed();
    test_random();
    drain();
    if (mismatches == 0 && expected_q.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/bpc_pkg.sv
rtl/bpc_sample_if.sv
rtl/bpc_result_if.sv
rtl/bpc_cfg_if.sv
rtl/bpc_div_cell.sv
rtl/bpc_div_chain.sv
rtl/barometric_pressure_compensation.sv
tb/barometric_pressure_compensation_tb.sv
